>>> hw/rtl/aesd_pkg.sv
// ----------------------------------------------------------------------------
// aesd_pkg
// types, constants and byte functions shared by the inverse cipher block
// ----------------------------------------------------------------------------
package aesd_pkg;

    localparam int NUM_ROUNDS_DEF = 10;
    localparam int BLOCK_BITS     = 128;
    localparam logic [8:0] GF_POLY = 9'h11b;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    typedef struct packed {
        logic        operation;
        logic [3:0]  key_index;
        logic [63:0] data_high;
        logic [63:0] data_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } out_item_t;

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        logic [8:0] v;
        v = {a, 1'b0};
        if (v[8])
        begin
            v = v ^ GF_POLY;
        end
        return v[7:0];
    endfunction

    // product with a 4-bit constant
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] c);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int b = 0; b < 4; b++)
        begin
            if (c[b])
            begin
                r = r ^ p;
            end
            p = xtime(p);
        end
        return r;
    endfunction

    // byte k (column-major) of a block, byte 0 in the top bits
    function automatic logic [7:0] blk_byte(input logic [127:0] s, input int k);
        return s[127 - 8 * k -: 8];
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127 - 8 * (4 * c + r) -: 8] =
                    INV_SBOX[blk_byte(s, 4 * ((c + 4 - r) % 4) + r)];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   col [4];
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                col[r] = blk_byte(s, 4 * c + r);
            end
            for (int r = 0; r < 4; r++)
            begin
                t[127 - 8 * (4 * c + r) -: 8] = gmul(col[r], 4'he)
                    ^ gmul(col[(r + 1) % 4], 4'hb) ^ gmul(col[(r + 2) % 4], 4'hd)
                    ^ gmul(col[(r + 3) % 4], 4'h9);
            end
        end
        return t;
    endfunction

endpackage

>>> hw/rtl/aes128_block_decrypt.sv
// ----------------------------------------------------------------------------
// aes128_block_decrypt
// AES inverse cipher with round keys held in a synchronous key memory
// ----------------------------------------------------------------------------
// A load transfer writes one round key into the key memory (indexes above
// NUM_ROUNDS are dropped). A decrypt transfer spends a fetch state on the first
// key memory read, then runs one shared round unit once per cycle, fed by one
// key memory read a cycle, the first of these passes being the initial key add.
// The result then sits in an output register, and the next transfer is accepted
// in the cycle that result is taken or any cycle after. All used round keys
// must be loaded before decrypting.
module aes128_block_decrypt #(
    parameter int NUM_ROUNDS = aesd_pkg::NUM_ROUNDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  aesd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output aesd_pkg::out_item_t out_data
);
    import aesd_pkg::*;

    localparam int DEPTH = NUM_ROUNDS + 1;
    localparam int RW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ROUND,
        ST_HOLD
    } state_t;

    logic [127:0]  key_mem [DEPTH];
    logic [127:0]  key_rd;
    logic [RW-1:0] rd_addr;

    state_t        state_reg, state_next;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic [127:0]  blk_reg, blk_next;
    logic          first_reg, first_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_reg, out_next;

    logic in_fire;
    logic out_fire;
    logic [127:0] ss;
    logic [127:0] ak;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || (state_reg == ST_HOLD && out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.operation == OP_LOAD && {28'd0, in_data.key_index} <= NUM_ROUNDS)
        begin
            key_mem[in_data.key_index[RW-1:0]] <= {in_data.data_high, in_data.data_low};
        end
        key_rd <= key_mem[rd_addr];
    end

    assign ss = inv_shift_sub(blk_reg);
    assign ak = first_reg ? (blk_reg ^ key_rd) : (ss ^ key_rd);

    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        blk_next       = blk_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_addr        = rnd_reg;
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE, ST_HOLD:
            begin
                if (state_reg == ST_HOLD && out_fire)
                begin
                    state_next = ST_IDLE;
                end
                if (in_fire && in_data.operation == OP_DECRYPT)
                begin
                    blk_next   = {in_data.data_high, in_data.data_low};
                    rnd_next   = RW'(NUM_ROUNDS);
                    first_next = 1'b1;
                    state_next = ST_FETCH;
                end
                else if (in_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                // key for rnd_reg now being read
                state_next = ST_ROUND;
                rnd_next   = rnd_reg - 1'b1;
            end
            ST_ROUND:
            begin
                first_next = 1'b0;
                if (first_reg || rnd_reg != RW'(NUM_ROUNDS))
                begin
                    blk_next = first_reg ? ak : inv_mix(ak);
                end
                if (!first_reg && rnd_reg == RW'(NUM_ROUNDS))
                begin
                    // final round: no mix, rnd wrapped to top as marker
                    out_next.plain_high = ak[127:64];
                    out_next.plain_low  = ak[63:0];
                    out_valid_next      = 1'b1;
                    state_next          = ST_HOLD;
                end
                else if (rnd_reg == '0)
                begin
                    rnd_next = RW'(NUM_ROUNDS);
                end
                else
                begin
                    rnd_next = rnd_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rnd_reg       <= '0;
            first_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rnd_reg       <= rnd_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        out_reg <= out_next;
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HOLD |-> out_valid_reg)
        else $error("hold state without pending result");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH || state_reg == ST_ROUND) |-> !in_ready)
        else $error("input accepted while a block is in flight");
    a_result_from_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_ROUND)
        else $error("result raised outside the last round");

endmodule

>>> tb/sv/aes128_block_decrypt_tb.sv
// ----------------------------------------------------------------------------
// aes128_block_decrypt_tb
// loads round keys and decrypts blocks under random idling on both channels;
// every plaintext is checked against an inverse cipher computed here
// ----------------------------------------------------------------------------
import aesd_pkg::*;

class plaintext_board;
    logic [127:0] round_keys [11];
    out_item_t    pending [$];
    int           errors;
    logic [7:0]   isb [256];

    static function logic [7:0] mul8(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                r = r ^ p;
            end
            p = p[7] ? ({p[6:0], 1'b0} ^ 8'h1b) : {p[6:0], 1'b0};
        end
        return r;
    endfunction

    function new();
        logic [7:0] x;
        logic [7:0] y;
        errors = 0;
        // build the inverse table from the forward s-box: affine of the inverse
        for (int i = 0; i < 256; i++)
        begin
            x = 8'h00;
            if (i != 0)
            begin
                for (int j = 1; j < 256; j++)
                begin
                    if (mul8(i[7:0], j[7:0]) == 8'h01)
                    begin
                        x = j[7:0];
                    end
                end
            end
            y = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
                ^ {x[3:0], x[7:4]} ^ 8'h63;
            isb[y] = i[7:0];
        end
    endfunction

    function logic [127:0] shift_sub(logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127 - 8 * (4 * c + r) -: 8] = isb[s[127 - 8 * (4 * ((c + 4 - r) % 4) + r) -: 8]];
            end
        end
        return t;
    endfunction

    function logic [127:0] unmix(logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   col [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                col[r] = s[127 - 8 * (4 * c + r) -: 8];
            end
            for (int r = 0; r < 4; r++)
            begin
                t[127 - 8 * (4 * c + r) -: 8] = mul8(col[r], 8'h0e)
                    ^ mul8(col[(r + 1) % 4], 8'h0b) ^ mul8(col[(r + 2) % 4], 8'h0d)
                    ^ mul8(col[(r + 3) % 4], 8'h09);
            end
        end
        return t;
    endfunction

    function void note_input(in_item_t it);
        logic [127:0] s;
        if (it.operation == OP_LOAD)
        begin
            if (it.key_index <= 10)
            begin
                round_keys[it.key_index] = {it.data_high, it.data_low};
            end
            return;
        end
        s = {it.data_high, it.data_low} ^ round_keys[10];
        for (int r = 9; r >= 1; r--)
        begin
            s = unmix(shift_sub(s) ^ round_keys[r]);
        end
        s = shift_sub(s) ^ round_keys[0];
        pending.push_back(s);
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (pending.size() == 0)
        begin
            $display("%0t unexpected plaintext %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.plain_high !== want.plain_high)
        begin
            $display("%0t plain_high expected %h actual %h", $time, want.plain_high,
                got.plain_high);
            errors++;
        end
        if (got.plain_low !== want.plain_low)
        begin
            $display("%0t plain_low expected %h actual %h", $time, want.plain_low,
                got.plain_low);
            errors++;
        end
    endfunction
endclass

module aes128_block_decrypt_tb;
    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    plaintext_board board;
    int send_idle;
    int recv_stall;
    int cycles;

    aes128_block_decrypt dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    initial
    begin
        clk = 0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                board.check_result(out_data);
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_item(input op_t op, input logic [3:0] idx,
                             input logic [63:0] hi, input logic [63:0] lo);
        in_item_t it;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        it.operation = op;
        it.key_index = idx;
        it.data_high = hi;
        it.data_low  = lo;
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        board.note_input(it);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                send_item(OP_DECRYPT, 4'($urandom_range(15)), rnd64(), rnd64());
            end
            else if (pick < 92)
            begin
                send_item(OP_LOAD, 4'($urandom_range(10)), rnd64(), rnd64());
            end
            else
            begin
                send_item(OP_LOAD, 4'($urandom_range(15, 11)), rnd64(), rnd64());
            end
        end
    endtask

    initial
    begin
        board = new();
        in_valid = 0;
        in_data = '0;
        out_ready = 0;
        send_idle = 0;
        recv_stall = 0;
        @(posedge rst_n);
        @(posedge clk);
        // every round key loaded before the first decrypt
        for (int k = 0; k <= 10; k++)
        begin
            send_item(OP_LOAD, k[3:0], rnd64(), rnd64());
        end
        send_item(OP_LOAD, 4'd15, '1, '1);
        send_item(OP_LOAD, 4'd11, '0, '0);
        send_item(OP_DECRYPT, 4'd0, '0, '0);
        send_item(OP_DECRYPT, 4'd15, '1, '1);
        send_item(OP_DECRYPT, 4'd5, 64'h8000000000000001, 64'h0123456789abcdef);
        send_item(OP_LOAD, 4'd0, '1, '1);
        send_item(OP_LOAD, 4'd10, '0, '0);
        send_item(OP_DECRYPT, 4'd10, rnd64(), rnd64());
        drain();
        random_phase(200);
        send_idle = 54;
        random_phase(200);
        drain();
        send_idle = 0;
        recv_stall = 54;
        random_phase(200);
        send_idle = 38;
        recv_stall = 38;
        random_phase(230);
        drain();
        if (board.errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/aesd_pkg.sv
hw/rtl/aes128_block_decrypt.sv
tb/sv/aes128_block_decrypt_tb.sv
